// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising edge, off during reset.
`define MPPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define MPPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MPPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mpps_pkg.sv =====
// Types, codes and defaults for the multi-policy process scheduler.
package mpps_pkg;

   localparam int DEF_MAX_TASKS = 16;
   localparam int DEF_TIME_BITS = 24;

   localparam int FIELD_TIME_W  = 24;
   localparam int FIELD_INDEX_W = 4;
   localparam int CSR_DATA_W    = 16;

   localparam logic [1:0]  CSR_POLICY     = 2'd0;
   localparam logic [1:0]  CSR_TASK_COUNT = 2'd1;
   localparam logic [1:0]  CSR_QUANTUM    = 2'd2;

   localparam logic [4:0]  TASK_COUNT_RESET = 5'd16;
   localparam logic [15:0] QUANTUM_RESET    = 16'd500;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      POLICY_FIFO = 2'd0,
      POLICY_RR   = 2'd1,
      POLICY_SJF  = 2'd2,
      POLICY_PSJF = 2'd3
   } policy_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIN_CHK,
      ST_WRAP,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK,
      ST_DEC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic tick_start;
      logic fin_chk;
      logic wrap_step;
      logic scan_rd;
      logic pick;
      logic dec;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic fin_done;
      logic wrap_ge;
      logic scan_last;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/mpps_controller.sv =====
// Sequencer that steps one scheduler transaction through finish check, scan and update.
module mpps_controller
   import mpps_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_operation,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;
   op_type    op;

   assign op = op_type'(req_operation);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && op == OP_TICK) begin
               state_in = stat.done ? ST_OUT : ST_FIN_CHK;
            end
         end
         ST_FIN_CHK: state_in = stat.fin_done ? ST_OUT : ST_WRAP;
         ST_WRAP: begin
            if (!stat.wrap_ge) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_PICK;
         ST_PICK:  state_in = ST_DEC;
         ST_DEC:   state_in = ST_OUT;
         ST_OUT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (op == OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.tick_start = 1'b1;
               end
            end
         end
         ST_FIN_CHK: cmd.fin_chk = 1'b1;
         ST_WRAP:    cmd.wrap_step = stat.wrap_ge;
         ST_SCAN:    cmd.scan_rd = 1'b1;
         ST_DRAIN:   cmd = '0;
         ST_PICK:    cmd.pick = 1'b1;
         ST_DEC:     cmd.dec = 1'b1;
         ST_OUT:     cmd.out_load = stat.out_free;
         default:    cmd = '0;
      endcase
   end

endmodule

// ===== rtl/mpps_datapath.sv =====
// Task tables, configuration registers, policy selection and result register.
module mpps_datapath
   import mpps_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   input  logic [FIELD_INDEX_W-1:0] req_entry_index,
   input  logic [FIELD_TIME_W-1:0]  req_ready_time,
   input  logic [FIELD_TIME_W-1:0]  req_run_time,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_running_valid,
   output logic [FIELD_INDEX_W-1:0] rsp_running_index,
   output logic                     rsp_finished_valid,
   output logic [FIELD_INDEX_W-1:0] rsp_finished_index,
   output logic                     rsp_all_done,
   output logic [FIELD_TIME_W-1:0]  rsp_tick_time
);

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W+4:0] MAX_EXT = (CNT_W + 5)'(MAX_TASKS);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);
   localparam logic [IDX_W+FIELD_INDEX_W-1:0] MAX_IDX_EXT =
      (IDX_W + FIELD_INDEX_W)'(MAX_TASKS);

   // configuration
   policy_type policy_ff, policy_in;
   logic [4:0]  task_count_ff, task_count_in;
   logic [15:0] quantum_ff, quantum_in;
   logic [CNT_W-1:0] n_cnt;
   logic [CNT_W+4:0] tc_ext;
   logic [15:0] q_val;

   // tables
   logic [TIME_BITS-1:0] arr_mem [MAX_TASKS];
   logic [TIME_BITS-1:0] rem_mem [MAX_TASKS];
   logic [TIME_BITS-1:0] arr_rd_ff;
   logic [TIME_BITS-1:0] rem_rd_ff;
   logic                 arr_we, rem_we, rem_re;
   logic [IDX_W-1:0]     rem_wa, rem_ra;
   logic [TIME_BITS-1:0] rem_wd;
   logic [IDX_W+FIELD_INDEX_W-1:0] load_idx_ext;
   logic                 load_ok;
   logic [IDX_W-1:0]     load_addr;
   logic [TIME_BITS+FIELD_TIME_W-1:0] rt_ext, run_ext;

   // scheduler state
   logic [MAX_TASKS-1:0] started_ff, started_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic [15:0]          slice_ff, slice_in;
   logic [TIME_BITS-1:0] clock_ff, clock_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic                 done_ff, done_in;

   // scan
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     start_ff, start_in;
   logic                 pend_ff;
   logic [IDX_W-1:0]     pend_idx_ff;
   logic                 first_v_ff, first_v_in;
   logic [IDX_W-1:0]     first_i_ff, first_i_in;
   logic                 best_v_ff, best_v_in;
   logic [IDX_W-1:0]     best_i_ff, best_i_in;
   logic [TIME_BITS-1:0] best_rem_ff, best_rem_in;
   logic                 rrf_v_ff, rrf_v_in;
   logic [IDX_W-1:0]     rrf_i_ff, rrf_i_in;
   logic                 st_j, run_j;

   // pick
   logic                 next_v;
   logic [IDX_W-1:0]     next_i;
   logic                 take;
   logic [IDX_W-1:0]     pick_cur;
   logic                 finishing;
   logic [16:0]          slice_inc;

   // results
   logic                 res_run_v_ff, res_run_v_in;
   logic [IDX_W-1:0]     res_run_i_ff, res_run_i_in;
   logic                 res_fin_v_ff, res_fin_v_in;
   logic [IDX_W-1:0]     res_fin_i_ff, res_fin_i_in;
   logic [TIME_BITS-1:0] res_time_ff, res_time_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_run_v_ff, rsp_fin_v_ff, rsp_done_ff;
   logic [FIELD_INDEX_W-1:0] rsp_run_i_ff, rsp_fin_i_ff;
   logic [FIELD_TIME_W-1:0]  rsp_time_ff;
   logic [IDX_W+FIELD_INDEX_W-1:0] run_i_ext, fin_i_ext;
   logic [TIME_BITS+FIELD_TIME_W-1:0] time_ext;

   // configuration port
   always_comb begin
      policy_in     = policy_ff;
      task_count_in = task_count_ff;
      quantum_in    = quantum_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY:     policy_in = policy_type'(csr_wdata[1:0]);
            CSR_TASK_COUNT: task_count_in = csr_wdata[4:0];
            CSR_QUANTUM:    quantum_in = csr_wdata;
            default:        policy_in = policy_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POLICY_FIFO;
         task_count_ff <= TASK_COUNT_RESET;
         quantum_ff    <= QUANTUM_RESET;
      end else begin
         policy_ff     <= policy_in;
         task_count_ff <= task_count_in;
         quantum_ff    <= quantum_in;
      end
   end

   always_comb begin
      tc_ext = {{CNT_W{1'b0}}, task_count_ff};
      if (task_count_ff == 5'd0) begin
         n_cnt = CNT_W'(1);
      end else if (tc_ext > MAX_EXT) begin
         n_cnt = MAX_CNT;
      end else begin
         n_cnt = tc_ext[CNT_W-1:0];
      end
   end

   assign q_val = (quantum_ff == 16'd0) ? 16'd1 : quantum_ff;

   // load decode
   assign load_idx_ext = {{IDX_W{1'b0}}, req_entry_index};
   assign load_ok      = load_idx_ext < MAX_IDX_EXT;
   assign load_addr    = load_idx_ext[IDX_W-1:0];
   assign rt_ext       = {{TIME_BITS{1'b0}}, req_ready_time};
   assign run_ext      = {{TIME_BITS{1'b0}}, req_run_time};

   // scan element and selection
   assign st_j      = started_ff[pend_idx_ff] | (arr_rd_ff == clock_ff);
   assign run_j     = st_j && (rem_rd_ff != '0);
   assign finishing = cur_valid_ff && (rem_rd_ff == '0);

   always_comb begin
      next_v = 1'b0;
      next_i = cur_ff;
      unique case (policy_ff)
         POLICY_FIFO: begin
            next_v = first_v_ff;
            next_i = first_i_ff;
         end
         POLICY_RR: begin
            if (!cur_valid_ff) begin
               next_v = first_v_ff;
               next_i = first_i_ff;
            end else if (slice_ff == 16'd0) begin
               next_v = rrf_v_ff | first_v_ff;
               next_i = rrf_v_ff ? rrf_i_ff : first_i_ff;
            end else begin
               next_v = 1'b1;
               next_i = cur_ff;
            end
         end
         POLICY_SJF: begin
            if (cur_valid_ff) begin
               next_v = 1'b1;
               next_i = cur_ff;
            end else begin
               next_v = best_v_ff;
               next_i = best_i_ff;
            end
         end
         POLICY_PSJF: begin
            next_v = best_v_ff;
            next_i = best_i_ff;
         end
         default: next_v = 1'b0;
      endcase
   end

   assign take      = cmd.pick && next_v && (!cur_valid_ff || next_i != cur_ff);
   assign pick_cur  = take ? next_i : cur_ff;
   assign slice_inc = {1'b0, slice_ff} + 17'd1;

   // table ports
   always_comb begin
      arr_we = cmd.load && load_ok;
      rem_we = 1'b0;
      rem_wa = load_addr;
      rem_wd = run_ext[TIME_BITS-1:0];
      if (cmd.load && load_ok) begin
         rem_we = 1'b1;
      end else if (cmd.dec && cur_valid_ff && rem_rd_ff != '0) begin
         rem_we = 1'b1;
         rem_wa = cur_ff;
         rem_wd = rem_rd_ff - TIME_BITS'(1);
      end
      rem_re = cmd.tick_start | cmd.scan_rd | cmd.pick;
      if (cmd.scan_rd) begin
         rem_ra = idx_ff;
      end else if (cmd.pick) begin
         rem_ra = pick_cur;
      end else begin
         rem_ra = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (arr_we) begin
         arr_mem[load_addr] <= rt_ext[TIME_BITS-1:0];
      end
      if (cmd.scan_rd) begin
         arr_rd_ff <= arr_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[rem_wa] <= rem_wd;
      end
      if (rem_re) begin
         rem_rd_ff <= rem_mem[rem_ra];
      end
   end

   // scheduler state update
   always_comb begin
      started_in   = started_ff;
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      slice_in     = slice_ff;
      clock_in     = clock_ff;
      total_in     = total_ff;
      done_in      = done_ff;
      idx_in       = idx_ff;
      start_in     = start_ff;
      first_v_in   = first_v_ff;
      first_i_in   = first_i_ff;
      best_v_in    = best_v_ff;
      best_i_in    = best_i_ff;
      best_rem_in  = best_rem_ff;
      rrf_v_in     = rrf_v_ff;
      rrf_i_in     = rrf_i_ff;
      res_run_v_in = res_run_v_ff;
      res_run_i_in = res_run_i_ff;
      res_fin_v_in = res_fin_v_ff;
      res_fin_i_in = res_fin_i_ff;
      res_time_in  = res_time_ff;

      if (cmd.load && load_ok) begin
         started_in[load_addr] = 1'b0;
      end

      if (cmd.tick_start) begin
         res_run_v_in = 1'b0;
         res_run_i_in = '0;
         res_fin_v_in = 1'b0;
         res_fin_i_in = '0;
         res_time_in  = clock_ff;
      end

      if (cmd.fin_chk) begin
         if (finishing) begin
            res_fin_v_in = 1'b1;
            res_fin_i_in = cur_ff;
            cur_valid_in = 1'b0;
            total_in     = total_ff + CNT_W'(1);
            if (total_ff + CNT_W'(1) >= n_cnt) begin
               done_in = 1'b1;
            end
         end
         start_in   = {1'b0, cur_ff} + CNT_W'(1);
         idx_in     = '0;
         first_v_in = 1'b0;
         best_v_in  = 1'b0;
         rrf_v_in   = 1'b0;
      end

      if (cmd.wrap_step) begin
         start_in = start_ff - n_cnt;
      end

      if (cmd.scan_rd) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      if (pend_ff) begin
         started_in[pend_idx_ff] = st_j;
         if (run_j) begin
            if (!first_v_ff) begin
               first_v_in = 1'b1;
               first_i_in = pend_idx_ff;
            end
            if (!best_v_ff || best_rem_ff > rem_rd_ff) begin
               best_v_in   = 1'b1;
               best_i_in   = pend_idx_ff;
               best_rem_in = rem_rd_ff;
            end
            if (!rrf_v_ff && {1'b0, pend_idx_ff} >= start_ff) begin
               rrf_v_in = 1'b1;
               rrf_i_in = pend_idx_ff;
            end
         end
      end

      if (take) begin
         cur_valid_in = 1'b1;
         cur_in       = next_i;
         slice_in     = 16'd0;
      end

      if (cmd.dec) begin
         if (cur_valid_ff) begin
            res_run_v_in = 1'b1;
            res_run_i_in = cur_ff;
         end
         slice_in = (slice_inc >= {1'b0, q_val}) ? 16'd0 : slice_inc[15:0];
         clock_in = clock_ff + TIME_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= '0;
         cur_valid_ff <= 1'b0;
         cur_ff       <= '0;
         slice_ff     <= '0;
         clock_ff     <= '0;
         total_ff     <= '0;
         done_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         first_v_ff   <= 1'b0;
         best_v_ff    <= 1'b0;
         rrf_v_ff     <= 1'b0;
         idx_ff       <= '0;
         start_ff     <= '0;
      end else begin
         started_ff   <= started_in;
         cur_valid_ff <= cur_valid_in;
         cur_ff       <= cur_in;
         slice_ff     <= slice_in;
         clock_ff     <= clock_in;
         total_ff     <= total_in;
         done_ff      <= done_in;
         pend_ff      <= cmd.scan_rd;
         first_v_ff   <= first_v_in;
         best_v_ff    <= best_v_in;
         rrf_v_ff     <= rrf_v_in;
         idx_ff       <= idx_in;
         start_ff     <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= idx_ff;
      first_i_ff   <= first_i_in;
      best_i_ff    <= best_i_in;
      best_rem_ff  <= best_rem_in;
      rrf_i_ff     <= rrf_i_in;
      res_run_v_ff <= res_run_v_in;
      res_run_i_ff <= res_run_i_in;
      res_fin_v_ff <= res_fin_v_in;
      res_fin_i_ff <= res_fin_i_in;
      res_time_ff  <= res_time_in;
   end

   // result register
   assign run_i_ext = {{FIELD_INDEX_W{1'b0}}, res_run_i_ff};
   assign fin_i_ext = {{FIELD_INDEX_W{1'b0}}, res_fin_i_ff};
   assign time_ext  = {{FIELD_TIME_W{1'b0}}, res_time_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_run_v_ff <= res_run_v_ff;
         rsp_run_i_ff <= run_i_ext[FIELD_INDEX_W-1:0];
         rsp_fin_v_ff <= res_fin_v_ff;
         rsp_fin_i_ff <= fin_i_ext[FIELD_INDEX_W-1:0];
         rsp_done_ff  <= done_ff;
         rsp_time_ff  <= time_ext[FIELD_TIME_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_running_valid  = rsp_run_v_ff;
   assign rsp_running_index  = rsp_run_i_ff;
   assign rsp_finished_valid = rsp_fin_v_ff;
   assign rsp_finished_index = rsp_fin_i_ff;
   assign rsp_all_done       = rsp_done_ff;
   assign rsp_tick_time      = rsp_time_ff;

   // status
   assign stat.done      = done_ff;
   assign stat.fin_done  = finishing && (total_ff + CNT_W'(1) >= n_cnt);
   assign stat.wrap_ge   = start_ff >= n_cnt;
   assign stat.scan_last = {1'b0, idx_ff} == (n_cnt - CNT_W'(1));
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

// ===== rtl/multi_policy_process_scheduler_top.sv =====
// Top level of the multi-policy process scheduler.
//
// Request channel (req_*): a load transaction writes one task table entry
// (arrival tick and run time) and clears its started flag; it is taken
// without leaving idle and gives no response. A tick advances the scheduler
// one time step unless the set is complete, and gives exactly one response.
// Response channel (rsp_*): the task that ran, the task that finished at the
// start of the tick, the all-done flag and the tick's clock value.
// Configuration (csr_*): policy, task count and quantum, one write per cycle.
// A tick steps through the finish check, the wrap of the round-robin start
// index, a scan of the N entries in use (N being the task count in use), a
// drain, the pick and the decrement before its response is loaded; the scan
// reads one table entry per cycle through the single read port of each table.
// A tick that completes the task set, or any later tick, skips the scan.
// One transaction is in work at a time.
// If the receiver stalls, the response holds in its output register; loads
// are still taken, and a following tick waits before its response is loaded.
// Reset (synchronous) clears flags, clock, counters and the running task and
// restores the default configuration; table contents are kept.
`include "assert_macros.svh"

module multi_policy_process_scheduler_top
   import mpps_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic [FIELD_INDEX_W-1:0] req_entry_index,
   input  logic [FIELD_TIME_W-1:0]  req_ready_time,
   input  logic [FIELD_TIME_W-1:0]  req_run_time,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_running_valid,
   output logic [FIELD_INDEX_W-1:0] rsp_running_index,
   output logic                     rsp_finished_valid,
   output logic [FIELD_INDEX_W-1:0] rsp_finished_index,
   output logic                     rsp_all_done,
   output logic [FIELD_TIME_W-1:0]  rsp_tick_time,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   mpps_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   mpps_datapath #(
      .MAX_TASKS (MAX_TASKS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_entry_index    (req_entry_index),
      .req_ready_time     (req_ready_time),
      .req_run_time       (req_run_time),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_running_valid  (rsp_running_valid),
      .rsp_running_index  (rsp_running_index),
      .rsp_finished_valid (rsp_finished_valid),
      .rsp_finished_index (rsp_finished_index),
      .rsp_all_done       (rsp_all_done),
      .rsp_tick_time      (rsp_tick_time)
   );

   `MPPS_ASSERT(a_cmd_onehot, clock, reset, $onehot0(cmd), "more than one datapath command")
   `MPPS_ASSERT_IMP(a_run_not_done, clock, reset, rsp_valid && rsp_running_valid, !rsp_all_done, "task ran on a completed tick")
   `MPPS_ASSERT_NXT(a_load_single, clock, reset, req_valid && req_ready && req_operation == OP_LOAD, req_ready, "load did not return to idle")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the multi-policy process scheduler top level.

import mpps_pkg::*;

typedef struct packed {
   logic                     run_v;
   logic [FIELD_INDEX_W-1:0] run_i;
   logic                     fin_v;
   logic [FIELD_INDEX_W-1:0] fin_i;
   logic                     done;
   logic [FIELD_TIME_W-1:0]  tick;
} tick_outcome_type;

class schedule_tracker;
   policy_type              policy;
   logic [4:0]              task_count;
   logic [15:0]             quantum;
   logic [FIELD_TIME_W-1:0] arrival_at [DEF_MAX_TASKS];
   logic [FIELD_TIME_W-1:0] ticks_left [DEF_MAX_TASKS];
   bit                      started    [DEF_MAX_TASKS];
   bit                      cur_valid;
   logic [3:0]              cur_entry;
   int                      slice_count;
   logic [FIELD_TIME_W-1:0] now_tick;
   int                      fin_total;
   bit                      all_finished;
   tick_outcome_type        due [$];
   int                      errors;

   function new();
      policy     = POLICY_FIFO;
      task_count = TASK_COUNT_RESET;
      quantum    = QUANTUM_RESET;
      foreach (started[i]) begin
         arrival_at[i] = '0;
         ticks_left[i] = '0;
         started[i]    = 1'b0;
      end
      cur_valid    = 1'b0;
      cur_entry    = '0;
      slice_count  = 0;
      now_tick     = '0;
      fin_total    = 0;
      all_finished = 1'b0;
      errors       = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_POLICY:     policy = policy_type'(data[1:0]);
         CSR_TASK_COUNT: task_count = data[4:0];
         CSR_QUANTUM:    quantum = data;
         default: ;
      endcase
   endfunction

   function int in_use();
      if (task_count == 0) return 1;
      if (task_count > DEF_MAX_TASKS) return DEF_MAX_TASKS;
      return int'(task_count);
   endfunction

   function bit runnable(int i, int n);
      return i < n && started[i] && ticks_left[i] != 0;
   endfunction

   function int first_ready(int n);
      for (int i = 0; i < n; i++)
         if (runnable(i, n)) return i;
      return -1;
   endfunction

   function int shortest(int n);
      int best;
      best = -1;
      for (int i = 0; i < n; i++)
         if (runnable(i, n) && (best < 0 || ticks_left[best] > ticks_left[i])) best = i;
      return best;
   endfunction

   function int choose(int n);
      int idx;
      case (policy)
         POLICY_FIFO: return first_ready(n);
         POLICY_RR: begin
            if (!cur_valid) return first_ready(n);
            if (slice_count != 0) return int'(cur_entry);
            for (int k = 1; k <= n; k++) begin
               idx = (int'(cur_entry) + k) % n;
               if (runnable(idx, n)) return idx;
            end
            return -1;
         end
         POLICY_SJF: return cur_valid ? int'(cur_entry) : shortest(n);
         default: return shortest(n);
      endcase
   endfunction

   function tick_outcome_type advance_tick();
      tick_outcome_type r;
      int n;
      int q;
      int next;
      n = in_use();
      q = (quantum == 0) ? 1 : int'(quantum);
      r = '0;
      r.tick = now_tick;
      if (!all_finished) begin
         if (cur_valid && ticks_left[cur_entry] == 0) begin
            r.fin_v   = 1'b1;
            r.fin_i   = cur_entry;
            cur_valid = 1'b0;
            fin_total++;
            if (fin_total >= n) all_finished = 1'b1;
         end
         if (!all_finished) begin
            for (int i = 0; i < n; i++)
               if (arrival_at[i] == now_tick) started[i] = 1'b1;
            next = choose(n);
            if (next >= 0 && (!cur_valid || next != int'(cur_entry))) begin
               cur_valid   = 1'b1;
               cur_entry   = 4'(next);
               slice_count = 0;
            end
            if (cur_valid) begin
               r.run_v = 1'b1;
               r.run_i = cur_entry;
               if (ticks_left[cur_entry] != 0) ticks_left[cur_entry]--;
            end
            slice_count++;
            if (slice_count >= q) slice_count = 0;
            now_tick++;
         end
      end
      r.done = all_finished;
      return r;
   endfunction

   function bit finish_pending();
      return !all_finished && cur_valid && ticks_left[cur_entry] == 0;
   endfunction

   function void take_request(op_type op, logic [3:0] idx, logic [FIELD_TIME_W-1:0] rt,
                              logic [FIELD_TIME_W-1:0] rn);
      if (op == OP_LOAD) begin
         arrival_at[idx] = rt;
         ticks_left[idx] = rn;
         started[idx]    = 1'b0;
      end else begin
         due.push_back(advance_tick());
      end
   endfunction

   task report_mismatch(string what);
      if (errors < 50) $display("MISMATCH %s", what);
      errors++;
   endtask

   task compare_field(string name, logic [FIELD_TIME_W-1:0] got,
                      logic [FIELD_TIME_W-1:0] want_v, logic [FIELD_TIME_W-1:0] at);
      if (got !== want_v)
         report_mismatch($sformatf("tick %0d %s: got %0d, expected %0d", at, name, got, want_v));
   endtask

   task check_tick(logic rv, logic [3:0] ri, logic fv, logic [3:0] fi, logic ad,
                   logic [FIELD_TIME_W-1:0] tt);
      tick_outcome_type want;
      if (due.size() == 0) begin
         report_mismatch($sformatf("response with nothing pending, tick_time %0d", tt));
         return;
      end
      want = due.pop_front();
      compare_field("running_valid", FIELD_TIME_W'(rv), FIELD_TIME_W'(want.run_v), want.tick);
      compare_field("running_index", FIELD_TIME_W'(ri), FIELD_TIME_W'(want.run_i), want.tick);
      compare_field("finished_valid", FIELD_TIME_W'(fv), FIELD_TIME_W'(want.fin_v),
                    want.tick);
      compare_field("finished_index", FIELD_TIME_W'(fi), FIELD_TIME_W'(want.fin_i),
                    want.tick);
      compare_field("all_done", FIELD_TIME_W'(ad), FIELD_TIME_W'(want.done), want.tick);
      compare_field("tick_time", tt, want.tick, want.tick);
   endtask
endclass

module testbench;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int          ITEM_TARGET = 850;
   localparam logic [1:0]  CSR_SPARE   = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_operation = 1'b0;
   logic [FIELD_INDEX_W-1:0] req_entry_index = '0;
   logic [FIELD_TIME_W-1:0]  req_ready_time = '0;
   logic [FIELD_TIME_W-1:0]  req_run_time = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_running_valid;
   logic [FIELD_INDEX_W-1:0] rsp_running_index;
   logic                     rsp_finished_valid;
   logic [FIELD_INDEX_W-1:0] rsp_finished_index;
   logic                     rsp_all_done;
   logic [FIELD_TIME_W-1:0]  rsp_tick_time;
   logic                     csr_we = 1'b0;
   logic [1:0]               csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   schedule_tracker tracker;
   int              items_sent = 0;
   bit              req_steady = 1'b0;
   int              stall_left = 0;
   int              calm_left = 0;
   int unsigned     cycles = 0;

   multi_policy_process_scheduler_top uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_tick(rsp_running_valid, rsp_running_index, rsp_finished_valid,
                            rsp_finished_index, rsp_all_done, rsp_tick_time);
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (calm_left != 0) calm_left <= calm_left - 1;
         else if ($urandom_range(0, 99) == 0) calm_left <= 300;
         else if ($urandom_range(0, 5) == 0)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(1, 3);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [FIELD_TIME_W-1:0] pick_ready();
      if ($urandom_range(0, 9) == 0) return FIELD_TIME_W'($urandom);
      return tracker.now_tick + FIELD_TIME_W'($urandom_range(0, 12));
   endfunction

   function automatic logic [FIELD_TIME_W-1:0] pick_run();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return FIELD_TIME_W'($urandom);
      return FIELD_TIME_W'($urandom_range(1, 14));
   endfunction

   task automatic send(op_type op, logic [3:0] idx, logic [FIELD_TIME_W-1:0] rt,
                       logic [FIELD_TIME_W-1:0] rn);
      int gap;
      gap = req_steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_entry_index <= idx;
      req_ready_time  <= rt;
      req_run_time    <= rn;
      do @(posedge clock); while (!req_ready);
      tracker.take_request(op, idx, rt, rn);
      items_sent++;
   endtask

   task automatic send_tick();
      send(OP_TICK, 4'($urandom), FIELD_TIME_W'($urandom), FIELD_TIME_W'($urandom));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   task automatic configure(policy_type pol, logic [4:0] tc, logic [15:0] qt);
      if ($urandom_range(0, 7) == 0) write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
      write_csr(CSR_POLICY, {14'($urandom), pol});
      write_csr(CSR_TASK_COUNT, {11'($urandom), tc});
      write_csr(CSR_QUANTUM, qt);
      csr_we <= 1'b0;
   endtask

   task automatic directed();
      send(OP_LOAD, 4'd0, 24'd0, 24'd1);
      send(OP_LOAD, 4'd1, 24'd0, 24'hFFFFFF);
      send(OP_LOAD, 4'd2, 24'd1, 24'd2);
      send(OP_LOAD, 4'd3, 24'hFFFFFF, 24'hFFFFFF);
      send(OP_LOAD, 4'd4, 24'd2, 24'd0);
      for (int i = 5; i < DEF_MAX_TASKS; i++)
         send(OP_LOAD, 4'(i), FIELD_TIME_W'(i), FIELD_TIME_W'(i));
      repeat (8) send_tick();
   endtask

   task automatic run_phase(int num, bit closing);
      policy_type  pol;
      logic [4:0]  tc;
      logic [15:0] qt;
      int          n;
      int          ticks;
      int          r;
      settle();
      req_steady = ($urandom_range(0, 4) == 0);
      pol = policy_type'($urandom_range(0, 3));
      r = $urandom_range(0, 9);
      tc = (r == 0) ? 5'd1 : (r == 1) ? 5'd16 : (r == 2) ? 5'($urandom_range(17, 31)) :
           (r == 3) ? 5'd0 : 5'($urandom_range(2, 8));
      r = $urandom_range(0, 9);
      qt = (r == 0) ? 16'hFFFF : (r == 1) ? 16'd0 : 16'($urandom_range(1, 6));
      case (num)
         0: begin pol = POLICY_RR;   tc = 5'd16; qt = 16'hFFFF; end
         1: begin pol = POLICY_RR;   tc = 5'd5;  qt = 16'd0;    end
         2: begin pol = POLICY_SJF;  tc = 5'd0;  qt = 16'd1;    end
         3: begin pol = POLICY_PSJF; tc = 5'd31; qt = 16'd1;    end
         4: begin pol = POLICY_FIFO; tc = 5'd1;  qt = 16'd3;    end
         default: ;
      endcase
      if (closing) tc = 5'($urandom_range(1, 4));
      configure(pol, tc, qt);
      n = tracker.in_use();
      for (int i = 0; i < n; i++)
         if (closing)
            send(OP_LOAD, 4'(i), tracker.now_tick + FIELD_TIME_W'($urandom_range(0, 4)),
                 FIELD_TIME_W'($urandom_range(1, 8)));
         else if ($urandom_range(0, 3) != 0)
            send(OP_LOAD, 4'(i), pick_ready(), pick_run());
      if (closing) begin
         if (tracker.cur_valid)
            send(OP_LOAD, tracker.cur_entry, tracker.now_tick, FIELD_TIME_W'($urandom_range(1, 4)));
         while (!tracker.all_finished) send_tick();
         repeat (6) send_tick();
      end else begin
         ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(8, 30);
         repeat (ticks) begin
            if ($urandom_range(0, 11) == 0)
               send(OP_LOAD, 4'($urandom), pick_ready(), pick_run());
            // hold off completion of the task set until the closing phase
            if (tracker.finish_pending() && (tracker.fin_total + 1 >= tracker.in_use() ||
                tracker.fin_total >= 12 || $urandom_range(0, 3) != 0))
               send(OP_LOAD, tracker.cur_entry,
                    tracker.now_tick + FIELD_TIME_W'($urandom_range(0, 3)),
                    FIELD_TIME_W'($urandom_range(1, 14)));
            send_tick();
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      directed();
      for (int p = 0; items_sent < ITEM_TARGET; p++) run_phase(p, 1'b0);
      run_phase(-1, 1'b1);
      req_valid <= 1'b0;
      while (tracker.due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (tracker.due.size() != 0)
         tracker.report_mismatch($sformatf("%0d responses never arrived", tracker.due.size()));
      if (tracker.errors == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end
endmodule
